// File: design/vid_pkg.sv
`timescale 1ns / 1ps

package vid_pkg;

  // Widths of the fields on the ports
  localparam int FIELD_BITS = 20;
  localparam int ID_BITS    = 11;

  // One face corner as it arrives
  typedef struct packed {
    logic                  start_mesh;
    logic [FIELD_BITS-1:0] position_index;
    logic [FIELD_BITS-1:0] texcoord_index;
    logic [FIELD_BITS-1:0] normal_index;
  } in_item_t;

  // One result as it leaves
  typedef struct packed {
    logic [ID_BITS-1:0] vertex_id;
    logic               is_new;
    logic               overflow;
  } out_item_t;

endpackage

// File: design/vid_ram.sv
`timescale 1ns / 1ps

module vid_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/vid_front.sv
`timescale 1ns / 1ps

module vid_front
  import vid_pkg::*;
#(
  parameter int INDEX_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  in_item_t                item,
  output logic                    q_vld,
  input  logic                    q_rdy,
  output logic [3*INDEX_BITS:0]   q_item
);

  localparam int QW = 3 * INDEX_BITS + 1;

  logic [QW-1:0] slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic [QW-1:0] q_word;
  logic          do_push;
  logic          do_pop;

  // Reduce each index to the stored width and attach the start flag
  always_comb begin
    q_word = {item.start_mesh,
              INDEX_BITS'({1'b0, item.position_index}),
              INDEX_BITS'({1'b0, item.texcoord_index}),
              INDEX_BITS'({1'b0, item.normal_index})};
  end

  assign full    = cnt[1];
  assign q_vld   = (cnt != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_vld && q_rdy;

  // Hold corners until the back part takes them
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= q_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("front queue occupancy out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("front queue pointers disagree with occupancy");

endmodule

// File: design/vid_back.sv
`timescale 1ns / 1ps

module vid_back
  import vid_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int INDEX_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_vld,
  output logic                  q_rdy,
  input  logic [3*INDEX_BITS:0] q_item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = 3 * INDEX_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  rd_idx;
  logic [AW-1:0]  cmp_idx;
  logic           cmp_vld;
  logic [KW-1:0]  key;
  logic           out_vld;
  out_item_t      res;

  logic           take;
  logic           re;
  logic [KW-1:0]  rdata;
  logic           hit;
  logic           miss_done;
  logic           tab_full;
  logic           we;
  logic [CW-1:0]  id_src;
  logic [CW+ID_BITS-1:0] id_wide;
  out_item_t      res_next;

  assign take      = (state == ST_IDLE) && q_vld && !out_vld;
  assign q_rdy     = take;
  assign re        = (state == ST_SCAN) && (rd_idx < count);
  assign hit       = (state == ST_SCAN) && cmp_vld && (rdata == key);
  assign miss_done = (state == ST_SCAN) && !cmp_vld && (rd_idx == count);
  assign tab_full  = (count == CW'(TABLE_DEPTH));
  assign we        = miss_done && !tab_full;

  vid_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (key),
    .re    (re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // Build the result: matched entry, appended entry, or overflow
  always_comb begin
    id_src  = hit ? CW'(cmp_idx) : count;
    id_wide = {{ID_BITS{1'b0}}, id_src};
    res_next.vertex_id = id_wide[ID_BITS-1:0];
    res_next.is_new    = miss_done && !tab_full;
    res_next.overflow  = miss_done && tab_full;
  end

  // Latch the key of the corner under search, and the result when a search ends
  always_ff @(posedge clk) begin
    if (take) begin
      key <= q_item[KW-1:0];
    end
    if (hit || miss_done) begin
      res <= res_next;
    end
  end

  // Scan the table one entry per cycle, then append or report
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_idx  <= '0;
      cmp_idx <= '0;
      cmp_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (q_item[KW]) begin
              count <= '0;
            end
            rd_idx  <= '0;
            cmp_vld <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit || miss_done) begin
            cmp_vld <= 1'b0;
            state   <= ST_IDLE;
          end else begin
            cmp_vld <= re;
            cmp_idx <= rd_idx[AW-1:0];
            if (re) begin
              rd_idx <= rd_idx + CW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (we) begin
        count <= count + CW'(1);
      end
      if (hit || miss_done) begin
        out_vld <= 1'b1;
      end else if (pop) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign empty  = !out_vld;
  assign result = res;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= count))
    else $error("scan index passed entry count");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(res.is_new && res.overflow))
    else $error("result both new and overflowed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (hit || miss_done) |-> !out_vld)
    else $error("result register overwritten before transfer");

endmodule

// File: design/vertex_index_dedup.sv
`timescale 1ns / 1ps

// Vertex deduplication for an index buffer. Each transfer in is one face corner
// (position, texture-coordinate and normal index); each transfer out gives the
// index of the first table entry holding that triple, appending it when it is
// new, or TABLE_DEPTH with overflow set when a new triple finds the table full.
// start_mesh empties the table before its corner is handled. A search reads the
// table from entry 0 upward until a match or the end of the filled entries; the
// search engine reads the table through a single RAM read port, one entry per
// cycle. A two-entry input queue keeps taking corners while a search runs, and
// a result register holds the finished result until it is popped; while a
// result waits, the next search does not start. The table needs no clearing
// after reset.
module vertex_index_dedup
  import vid_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int INDEX_BITS  = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic                  q_vld;
  logic                  q_rdy;
  logic [3*INDEX_BITS:0] q_item;

  vid_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_vld  (q_vld),
    .q_rdy  (q_rdy),
    .q_item (q_item)
  );

  vid_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_vld  (q_vld),
    .q_rdy  (q_rdy),
    .q_item (q_item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import vid_pkg::*;

  localparam int VERTEX_SLOTS = 1024;
  localparam int KEY_BITS     = 3 * FIELD_BITS;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT_NS = 20_000_000;

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  int send_idle_pct = 0;
  int pop_idle_pct  = 0;
  int err_count     = 0;

  // Vertex table as the block should hold it: key -> index, plus keys in order
  int unsigned           vertex_of_key[logic [KEY_BITS-1:0]];
  logic [KEY_BITS-1:0]   vertex_keys[$];
  out_item_t             predicted_ids[$];

  vertex_index_dedup #(
    .TABLE_DEPTH(VERTEX_SLOTS),
    .INDEX_BITS (FIELD_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Work out the id one corner should get and update the table copy
  function automatic out_item_t dedup_corner(in_item_t c);
    logic [KEY_BITS-1:0] key;
    out_item_t           r;
    if (c.start_mesh) begin
      vertex_of_key.delete();
      vertex_keys.delete();
    end
    key = {c.position_index, c.texcoord_index, c.normal_index};
    if (vertex_of_key.exists(key)) begin
      r = '{vertex_id: ID_BITS'(vertex_of_key[key]), is_new: 1'b0, overflow: 1'b0};
    end else if (vertex_keys.size() >= VERTEX_SLOTS) begin
      r = '{vertex_id: ID_BITS'(VERTEX_SLOTS), is_new: 1'b0, overflow: 1'b1};
    end else begin
      r = '{vertex_id: ID_BITS'(vertex_keys.size()), is_new: 1'b1, overflow: 1'b0};
      vertex_of_key[key] = vertex_keys.size();
      vertex_keys.insert(vertex_keys.size(), key);
    end
    return r;
  endfunction

  // Mostly random indices, with the extremes and tiny values mixed in
  function automatic logic [FIELD_BITS-1:0] pick_index();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return FIELD_BITS'($urandom_range(15));
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  // Transfer one corner in, with a random gap first; record its expected id
  task automatic send_corner(in_item_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    item <= c;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predicted_ids.insert(predicted_ids.size(), dedup_corner(c));
  endtask

  // Hold the sender off until every expected id has come back
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (predicted_ids.size() != 0) @(negedge clk);
  endtask

  // Receiver: drop pop at random
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_id;
    if (!rst && pop && !empty) begin
      if (predicted_ids.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: id=%0d new=%0b ovf=%0b",
                   result.vertex_id, result.is_new, result.overflow);
      end else begin
        exp_id = predicted_ids.pop_front();
        if (result.vertex_id !== exp_id.vertex_id || result.is_new !== exp_id.is_new ||
            result.overflow !== exp_id.overflow) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: expected id=%0d new=%0b ovf=%0b, got id=%0d new=%0b ovf=%0b",
                     exp_id.vertex_id, exp_id.is_new, exp_id.overflow,
                     result.vertex_id, result.is_new, result.overflow);
        end
      end
    end
  end

  // Hand-picked corners: extremes, single-field differences, restarts
  task automatic test_directed();
    in_item_t zeros, ones, pos_one, tex_one, nrm_one, mixed;
    zeros   = '{start_mesh: 1'b0, position_index: '0, texcoord_index: '0, normal_index: '0};
    ones    = '{start_mesh: 1'b0, position_index: '1, texcoord_index: '1, normal_index: '1};
    pos_one = zeros;
    pos_one.position_index = FIELD_BITS'(1);
    tex_one = zeros;
    tex_one.texcoord_index = FIELD_BITS'(1);
    nrm_one = zeros;
    nrm_one.normal_index = FIELD_BITS'(1);
    mixed = '{start_mesh: 1'b0, position_index: 20'h80000, texcoord_index: 20'h00001,
              normal_index: 20'h7FFFF};
    // table is empty after reset, no start needed
    send_corner(zeros);
    send_corner(zeros);
    send_corner(ones);
    send_corner(pos_one);
    send_corner(tex_one);
    send_corner(nrm_one);
    send_corner(ones);
    wait_drained();
    send_corner(mixed);
    send_corner(zeros);
    send_corner(nrm_one);
    // restart on a busy table, then bring back an old triple
    ones.start_mesh = 1'b1;
    send_corner(ones);
    send_corner(zeros);
    ones.start_mesh = 1'b0;
    send_corner(ones);
    zeros.start_mesh = 1'b1;
    send_corner(zeros);
    send_corner(zeros);
    zeros.start_mesh = 1'b0;
    send_corner(zeros);
  endtask

  // Fill every slot, then probe overflow, hits on a full table and a restart
  task automatic test_table_full();
    logic [KEY_BITS-1:0] old_key;
    in_item_t            c;
    for (int i = 0; i < VERTEX_SLOTS; i++) begin
      c = '{start_mesh: (i == 0), position_index: FIELD_BITS'(i),
            texcoord_index: ~FIELD_BITS'(i), normal_index: FIELD_BITS'($urandom)};
      send_corner(c);
    end
    repeat (3) begin
      c = '{start_mesh: 1'b0,
            position_index: FIELD_BITS'($urandom_range(2 ** FIELD_BITS - 1, VERTEX_SLOTS)),
            texcoord_index: pick_index(), normal_index: pick_index()};
      send_corner(c);
    end
    send_corner(in_item_t'({1'b0, vertex_keys[0]}));
    send_corner(in_item_t'({1'b0, vertex_keys[VERTEX_SLOTS-1]}));
    send_corner(in_item_t'({1'b0, vertex_keys[$urandom_range(VERTEX_SLOTS-1)]}));
    c.normal_index = ~c.normal_index;
    send_corner(c);
    // start on a full table lands on slot 0; an old triple is new again
    old_key = vertex_keys[5];
    send_corner(in_item_t'({1'b1, pick_index(), pick_index(), pick_index()}));
    send_corner(in_item_t'({1'b0, old_key}));
  endtask

  // Meshes from small pools of triples with random content, plus noise
  task automatic test_random_meshes(int n_corners);
    logic [KEY_BITS-1:0] pool[$];
    logic [KEY_BITS-1:0] key;
    in_item_t            c;
    int                  sent;
    int                  kind;
    int                  mesh_len;
    sent = 0;
    while (sent < n_corners) begin
      kind     = $urandom_range(99);
      mesh_len = $urandom_range(40, 3);
      pool.delete();
      repeat ($urandom_range(16, 1)) begin
        key = {pick_index(), pick_index(), pick_index()};
        // near misses: one bit away from a pool entry
        if (pool.size() != 0 && $urandom_range(3) == 0) begin
          key = pool[$urandom_range(pool.size() - 1)];
          key[$urandom_range(KEY_BITS - 1)] ^= 1'b1;
        end
        pool.insert(pool.size(), key);
      end
      for (int k = 0; k < mesh_len && sent < n_corners; k++) begin
        if (kind < 85) begin
          c = in_item_t'({(k == 0) || ($urandom_range(49) == 0),
                          pool[$urandom_range(pool.size() - 1)]});
        end else begin
          c = in_item_t'({$urandom_range(9) == 0, pick_index(), pick_index(), pick_index()});
        end
        if ($urandom_range(99) == 0)
          wait_drained();
        send_corner(c);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    pop_idle_pct  = 77;
    test_directed();
    test_random_meshes(190);

    send_idle_pct = 77;
    pop_idle_pct  = 13;
    test_random_meshes(195);

    send_idle_pct = 0;
    pop_idle_pct  = 0;
    test_table_full();
    test_random_meshes(195);

    wait_drained();
    repeat (VERTEX_SLOTS + 16) @(negedge clk);
    if (predicted_ids.size() != 0) begin
      err_count += predicted_ids.size();
      $display("%0d results never arrived", predicted_ids.size());
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/vid_pkg.sv
design/vid_ram.sv
design/vid_front.sv
design/vid_back.sv
design/vertex_index_dedup.sv
tb/sv/tb.sv
